// File: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/mbps_pkg.sv
// Shared constants and types for the masked byte pattern scanner.
`timescale 1ns / 1ps
package mbps_pkg;

  localparam int PATTERN_MAX_DEF = 16;
  localparam int BYTE_W          = 8;
  localparam int ADDR_W          = 64;
  localparam int CARE_W          = 16;
  localparam int LEN_FIELD_W     = 5;
  localparam int PAT_IDX_W       = 4;
  localparam int CFG_IDX_W       = 8;
  localparam int CFG_DATA_W      = 64;
  localparam int IN_DATA_W       = BYTE_W + ADDR_W;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK      = 8'd3;

  localparam logic [CARE_W-1:0] CARE_RESET = 16'hFFFF;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [ADDR_W-1:0] addr_t;

endpackage

// File: hdl/masked_byte_pattern_scanner_top.sv
// Top level of the masked byte pattern scanner.
//
//  channel | dir | beat contents
//  --------+-----+-----------------------------------------------------------
//  in_     | in  | tdata: data_byte, byte_address; tuser: first_of_region
//  out_    | out | tdata: match_address
//  cfg_    | in  | index 0 length, 1 pattern low, 2 pattern high, 3 care mask
//
// One beat per cycle while out_ is not stalled; a match result reaches out_ through the input and result registers.
// Input register -> compare against the age-aligned pattern -> result register.
// Synchronous active-low reset; no clearing pass, ready right after reset.
// A stalled out_ holds one result and one further input beat, then in_tready drops.
// cfg_ is always ready; the derived compare view updates with the write.
`timescale 1ns / 1ps
module masked_byte_pattern_scanner_top
  import mbps_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] data_byte, [71:8] byte_address
  input  logic                  in_tuser,   // [0] first_of_region
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [ADDR_W-1:0]     out_tdata,  // [63:0] match_address
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int FILL_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  byte_t [PATTERN_MAX-1:0] pat_age;
  logic  [PATTERN_MAX-1:0] care_age;
  logic  [FILL_W-1:0]      len_m1;

  logic  a_valid_r;
  byte_t a_byte_r;
  addr_t a_addr_r;
  logic  a_first_r;
  logic  a_adv, hit;

  logic  o_valid_r, o_valid_nxt;
  addr_t o_addr_r;

  assign cfg_ready = 1'b1;

  mbps_cfg #(.PATTERN_MAX(PATTERN_MAX)) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pat_age  (pat_age),
    .care_age (care_age),
    .len_m1   (len_m1)
  );

  assign a_adv     = a_valid_r && (!o_valid_r || out_tready);
  assign in_tready = !a_valid_r || a_adv;

  mbps_window #(.PATTERN_MAX(PATTERN_MAX)) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (a_adv),
    .cur_byte(a_byte_r),
    .first   (a_first_r),
    .pat_age (pat_age),
    .care_age(care_age),
    .len_m1  (len_m1),
    .hit     (hit)
  );

  always_comb begin
    o_valid_nxt = o_valid_r;
    if (a_adv) begin
      o_valid_nxt = hit;
    end else if (out_tready) begin
      o_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        a_valid_r <= in_tvalid;
      end
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      a_byte_r  <= in_tdata[BYTE_W-1:0];
      a_addr_r  <= in_tdata[BYTE_W +: ADDR_W];
      a_first_r <= in_tuser;
    end
    if (a_adv) begin
      // window start address, wraps modulo 2^64
      o_addr_r <= a_addr_r - {{(ADDR_W-FILL_W){1'b0}}, len_m1};
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_tdata  = o_addr_r;

endmodule

// File: hdl/mbps_cfg.sv
// Configuration registers and the age-aligned pattern and care view.
`timescale 1ns / 1ps
module mbps_cfg
  import mbps_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  input  logic [CFG_IDX_W-1:0]               cfg_index,
  input  logic [CFG_DATA_W-1:0]              cfg_data,
  output byte_t [PATTERN_MAX-1:0]            pat_age,
  output logic  [PATTERN_MAX-1:0]            care_age,
  output logic  [((PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1)-1:0] len_m1
);

  localparam int FILL_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LEN_W  = $clog2(PATTERN_MAX + 1);

  logic [LEN_W-1:0]      len_r, len_nxt, len_src;
  addr_t                 pat_lo_r, pat_lo_nxt, pat_lo_src;
  addr_t                 pat_hi_r, pat_hi_nxt, pat_hi_src;
  logic [CARE_W-1:0]     care_r, care_nxt, care_src;
  logic [LEN_FIELD_W-1:0] len_raw;

  byte_t [PATTERN_MAX-1:0] pat_age_r, pat_age_nxt;
  logic  [PATTERN_MAX-1:0] care_age_r, care_age_nxt;
  logic  [FILL_W-1:0]      len_m1_r, len_m1_nxt;
  logic  [2*ADDR_W-1:0]    pat_all;

  assign len_raw = cfg_data[LEN_FIELD_W-1:0];

  always_comb begin
    len_nxt    = len_r;
    pat_lo_nxt = pat_lo_r;
    pat_hi_nxt = pat_hi_r;
    care_nxt   = care_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_PATTERN_LENGTH: begin
          if (len_raw == '0) begin
            len_nxt = LEN_W'(1);
          end else if (int'(len_raw) > PATTERN_MAX) begin
            len_nxt = LEN_W'(PATTERN_MAX);
          end else begin
            len_nxt = LEN_W'(len_raw);
          end
        end
        REG_PATTERN_LOW:  pat_lo_nxt = cfg_data;
        REG_PATTERN_HIGH: pat_hi_nxt = cfg_data;
        REG_CARE_MASK:    care_nxt   = cfg_data[CARE_W-1:0];
        default: ;
      endcase
    end
  end

  // reset values feed the derived view directly so it is right from the first beat
  assign len_src    = rst_n ? len_nxt    : LEN_W'(1);
  assign pat_lo_src = rst_n ? pat_lo_nxt : '0;
  assign pat_hi_src = rst_n ? pat_hi_nxt : '0;
  assign care_src   = rst_n ? care_nxt   : CARE_RESET;
  assign pat_all    = {pat_hi_src, pat_lo_src};

  // age 0 is the newest byte, compared against pattern byte len-1
  always_comb begin
    logic [PAT_IDX_W-1:0] jdx;
    logic [PAT_IDX_W+2:0] bsel;
    jdx = '0;
    bsel = '0;
    for (int a = 0; a < PATTERN_MAX; a++) begin
      jdx  = PAT_IDX_W'(int'(len_src) - 1 - a);
      bsel = {jdx, 3'b000};
      if (a < int'(len_src)) begin
        pat_age_nxt[a]  = pat_all[bsel +: BYTE_W];
        care_age_nxt[a] = care_src[jdx];
      end else begin
        pat_age_nxt[a]  = '0;
        care_age_nxt[a] = 1'b0;
      end
    end
    len_m1_nxt = FILL_W'(len_src - LEN_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= LEN_W'(1);
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      care_r   <= CARE_RESET;
    end else begin
      len_r    <= len_nxt;
      pat_lo_r <= pat_lo_nxt;
      pat_hi_r <= pat_hi_nxt;
      care_r   <= care_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pat_age_r  <= pat_age_nxt;
    care_age_r <= care_age_nxt;
    len_m1_r   <= len_m1_nxt;
  end

  assign pat_age  = pat_age_r;
  assign care_age = care_age_r;
  assign len_m1   = len_m1_r;

endmodule

// File: hdl/mbps_window.sv
// Byte history window, region fill count and masked compare.
`timescale 1ns / 1ps
module mbps_window
  import mbps_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  byte_t                   cur_byte,
  input  logic                    first,
  input  byte_t [PATTERN_MAX-1:0] pat_age,
  input  logic  [PATTERN_MAX-1:0] care_age,
  input  logic  [((PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1)-1:0] len_m1,
  output logic                    hit
);

  localparam int FILL_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int WIN_D  = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(PATTERN_MAX - 1);

  byte_t [WIN_D-1:0]       win_r;
  logic  [FILL_W-1:0]      fill_r, fill_nxt, fill_eff;
  byte_t [PATTERN_MAX-1:0] age_b;
  logic  [PATTERN_MAX-1:0] eq;

  // bytes older than the fill count are never looked at, so a new region
  // only needs the count cleared
  assign fill_eff = first ? '0 : fill_r;
  assign fill_nxt = (fill_eff < FILL_MAX) ? fill_eff + FILL_W'(1) : fill_eff;

  assign age_b[0] = cur_byte;
  for (genvar a = 1; a < PATTERN_MAX; a++) begin : g_age
    assign age_b[a] = win_r[a-1];
  end

  for (genvar a = 0; a < PATTERN_MAX; a++) begin : g_eq
    assign eq[a] = !care_age[a] || (age_b[a] == pat_age[a]);
  end

  assign hit = (fill_eff >= len_m1) && (&eq);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (adv) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      win_r[0] <= cur_byte;
      for (int k = 1; k < WIN_D; k++) begin
        win_r[k] <= win_r[k-1];
      end
    end
  end

endmodule

// File: hdl/mbps_checker.sv
// Port-level checks for the masked byte pattern scanner, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mbps_checker
  import mbps_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [ADDR_W-1:0] out_tdata
);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `ASSERT_NEXT(a_out_data_hold, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))
  `ASSERT_IMPLY(a_ready_when_free, clk, rst_n, !out_tvalid || out_tready, in_tready)
  `ASSERT_IMPLY(a_quiet_after_reset, clk, rst_n, !$past(rst_n), !out_tvalid)

endmodule

bind masked_byte_pattern_scanner_top mbps_checker u_mbps_checker (.*);

// File: test/tb_masked_byte_pattern_scanner_top.sv
// Self-checking testbench for masked_byte_pattern_scanner_top: directed and random scans.
`timescale 1ns / 1ps
module tb_masked_byte_pattern_scanner_top;
  import mbps_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [7:0] data_byte, [71:8] byte_address
  logic                  in_tuser = 1'b0; // [0] first_of_region
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [ADDR_W-1:0]     out_tdata;       // [63:0] match_address
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  masked_byte_pattern_scanner_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // scanner state as predicted
  logic [LEN_FIELD_W-1:0] len_reg = 5'd1;
  logic [63:0]            pat_lo = '0;
  logic [63:0]            pat_hi = '0;
  logic [CARE_W-1:0]      care_bits = CARE_RESET;
  byte_t                  hist [PATTERN_MAX_DEF-1];
  int                     hist_fill = 0;

  addr_t match_addr_q [$];
  addr_t expected_addr;
  addr_t next_addr = '0;
  int    errors = 0;
  int    in_gap_pct = 30;
  int    out_stall_pct = 30;
  int    stall_cnt = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int eff_len();
    if (len_reg == 0) return 1;
    if (len_reg > PATTERN_MAX_DEF) return PATTERN_MAX_DEF;
    return len_reg;
  endfunction

  function automatic void scan_byte(input byte_t b, input addr_t a, input logic first);
    int          n;
    logic        hit;
    byte_t       seen;
    logic [127:0] pat;
    n = eff_len();
    pat = {pat_hi, pat_lo};
    if (first) begin
      foreach (hist[k]) hist[k] = '0;
      hist_fill = 0;
    end
    hit = (hist_fill + 1 >= n);
    for (int j = 0; j < n; j++) begin
      if (j == n - 1) seen = b;
      else seen = hist[n - 2 - j];
      if (care_bits[j] && seen != pat[8*j +: 8]) hit = 1'b0;
    end
    if (hit) match_addr_q.insert(match_addr_q.size(), a - addr_t'(n - 1));
    for (int k = PATTERN_MAX_DEF - 2; k > 0; k--) hist[k] = hist[k-1];
    hist[0] = b;
    if (hist_fill < PATTERN_MAX_DEF - 1) hist_fill++;
  endfunction

  // one input beat at next_addr; in_tvalid stays high when no gap follows
  task automatic send_beat(input byte_t b, input logic first);
    int gap;
    gap = ($urandom_range(99) < in_gap_pct) ? idle_len() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {next_addr, b};
    in_tuser  <= first;
    do @(posedge clk); while (!in_tready);
    scan_byte(b, next_addr, first);
    next_addr = next_addr + 1'b1;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PATTERN_LENGTH: len_reg = val[LEN_FIELD_W-1:0];
      REG_PATTERN_LOW:    pat_lo = val;
      REG_PATTERN_HIGH:   pat_hi = val;
      REG_CARE_MASK:      care_bits = val[CARE_W-1:0];
      default: ;
    endcase
  endtask

  // all four registers plus one write to an unused index; junk in unused upper bits
  task automatic load_config(input logic [LEN_FIELD_W-1:0] len, input logic [63:0] lo,
                             input logic [63:0] hi, input logic [CARE_W-1:0] mask);
    write_reg(REG_PATTERN_LENGTH, {32'($urandom), 27'($urandom), len});
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_CARE_MASK, {32'($urandom), 16'($urandom), mask});
    write_reg(CFG_IDX_W'($urandom_range(int'(REG_CARE_MASK) + 1, (1 << CFG_IDX_W) - 1)),
              {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  task automatic settle_idle();
    in_tvalid <= 1'b0;
    while (match_addr_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (stall_cnt != 0) begin
      stall_cnt <= stall_cnt - 1;
    end else if (out_tready && $urandom_range(99) < out_stall_pct) begin
      out_tready <= 1'b0;
      stall_cnt  <= idle_len() - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (match_addr_q.size() == 0) begin
        $display("%0t: match_address expected none, got %h", $time, out_tdata);
        errors++;
      end else begin
        expected_addr = match_addr_q.pop_front();
        if (out_tdata !== expected_addr) begin
          $display("%0t: match_address expected %h, got %h", $time, expected_addr, out_tdata);
          errors++;
        end
      end
    end
  end

  // reset config: length 1, pattern byte zero; address wraps after all ones
  task automatic test_reset_defaults();
    next_addr = '1;
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b0);
  endtask

  task automatic test_length_floor();
    settle_idle();
    load_config(5'd0, {$urandom, 24'($urandom), 8'hA5}, {$urandom, $urandom}, 16'hFFFF);
    next_addr = {$urandom, $urandom};
    send_beat(8'hA5, 1'b1);
    send_beat(8'h5A, 1'b0);
  endtask

  // length 31 clamps to 16; window start wraps below zero
  task automatic test_length_ceiling_wrap();
    logic [127:0] pat;
    settle_idle();
    load_config(5'd31, {$urandom, $urandom}, {$urandom, $urandom}, 16'hFFFF);
    pat = {pat_hi, pat_lo};
    next_addr = '1 - 64'd7;
    for (int j = 0; j < PATTERN_MAX_DEF; j++) send_beat(pat[8*j +: 8], j == 0);
  endtask

  // byte 0 wildcard, care bits past the length ignored, region start empties window
  task automatic test_wildcards_regions();
    settle_idle();
    load_config(5'd2, {$urandom, 16'($urandom), 8'h3C, 8'($urandom)}, {$urandom, $urandom},
                16'hFFFE);
    next_addr = {$urandom, $urandom};
    send_beat(byte_t'($urandom), 1'b1);
    send_beat(8'h3C, 1'b1);
    send_beat(8'h3C, 1'b0);
  endtask

  task automatic test_random_scan();
    logic [LEN_FIELD_W-1:0] len;
    logic [CARE_W-1:0]      mask;
    logic [127:0]           pat;
    int                     sent;
    int                     n;
    int                     r;
    int                     spoil;
    int                     cut;
    byte_t                  b;
    for (int p = 0; p < 10; p++) begin
      settle_idle();
      case (p)
        0: len = 5'd16;
        1: len = 5'd1;
        2: len = 5'd0;
        3: len = 5'd31;
        default: len = ($urandom_range(3) == 0) ? 5'($urandom_range(17, 31))
                                                : 5'($urandom_range(1, 16));
      endcase
      if (p == 4) mask = '0;
      else if (p == 5) mask = '1;
      else mask = CARE_W'($urandom);
      in_gap_pct    = (p == 6) ? 0 : (p == 7) ? 70 : 30;
      out_stall_pct = in_gap_pct;
      load_config(len, {$urandom, $urandom}, {$urandom, $urandom}, mask);
      pat = {pat_hi, pat_lo};
      sent = 0;
      while (sent < 90) begin
        r = $urandom_range(99);
        if (r < 55) begin
          // embedded pattern, sometimes spoilt or cut by a region start
          n = eff_len();
          spoil = -1;
          cut = -1;
          if ($urandom_range(4) == 0) spoil = $urandom_range(n - 1);
          if ($urandom_range(9) == 0) cut = $urandom_range(n - 1);
          for (int j = 0; j < n; j++) begin
            b = care_bits[j] ? pat[8*j +: 8] : byte_t'($urandom);
            if (j == spoil) b = b ^ byte_t'($urandom_range(1, 255));
            send_beat(b, j == cut);
          end
          sent += n;
        end else if (r < 92) begin
          send_beat(byte_t'($urandom), 1'b0);
          sent++;
        end else begin
          r = $urandom_range(3);
          if (r == 0) next_addr = '1 - addr_t'($urandom_range(20));
          else if (r == 1) next_addr = addr_t'($urandom_range(20));
          else next_addr = {$urandom, $urandom};
          send_beat(byte_t'($urandom), 1'b1);
          sent++;
        end
      end
    end
  endtask

  initial begin
    foreach (hist[k]) hist[k] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_length_floor();
    test_length_ceiling_wrap();
    test_wildcards_regions();
    test_random_scan();
    settle_idle();
    if (errors == 0) begin
      $display("masked_byte_pattern_scanner_top: match");
    end else begin
      $display("masked_byte_pattern_scanner_top: mismatch");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("masked_byte_pattern_scanner_top: mismatch");
    $finish;
  end

endmodule
